### design/piecewise_linear_table_interp_top_macros.svh
// assertion macros for the piecewise linear interpolation table
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PWLTI_AST_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pwlti assertion failed");

// antecedent implies consequent in the next cycle
`define PWLTI_AST_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pwlti assertion failed");

`endif

### design/pwlti_pkg.sv
// shared types, codes and constants of the piecewise linear interpolation table
`timescale 1ns / 1ps
package pwlti_pkg;
	localparam int unsigned MAX_POINTS_DEF = 1024;
	localparam int unsigned MATCH_TOL_DEF  = 107;

	localparam logic [31:0] TOP_RADIUS_RST = 32'h4000_0000;

	localparam int unsigned LIM_W  = 56;
	localparam logic signed [LIM_W-1:0] ETA_LO_MUL = 56'sd1000000;
	localparam logic signed [LIM_W-1:0] ETA_HI_MUL = 56'sd10000;

	localparam int unsigned QUOT_W = 31;
	localparam int unsigned NUM_W  = 64;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_STORED  = 3'd1;
	localparam logic [2:0] STS_CLEARED = 3'd2;
	localparam logic [2:0] STS_NOT_INC = 3'd3;
	localparam logic [2:0] STS_FULL    = 3'd4;
	localparam logic [2:0] STS_TOO_FEW = 3'd5;
	localparam logic [2:0] STS_RANGE   = 3'd6;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        radius;
		logic signed [31:0] point_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic [2:0]         status;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SEG_LO,
		S_SEG_HI,
		S_SEG_CHK,
		S_LIM,
		S_LIM_CHK,
		S_DIV,
		S_MUL,
		S_FIN,
		S_DONE
	} state_t;
endpackage

### design/pwlti_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pwlti_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pwlti_pkg::NUM_W-1:0] num,
	input  logic [31:0]                den,
	output logic                       done,
	output logic [pwlti_pkg::QUOT_W-1:0] quot
);
	import pwlti_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       rem_q;
	logic [QUOT_W-1:0] low_q;
	logic [QUOT_W-1:0] quot_q;
	logic [31:0]       den_q;
	logic [33:0]       trial;
	logic              ge;

	assign trial = {1'b0, rem_q, low_q[QUOT_W-1]} - {2'b00, den_q};
	assign ge    = ~trial[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[NUM_W-2:QUOT_W];
			low_q  <= num[QUOT_W-1:0];
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? trial[31:0] : {rem_q[30:0], low_q[QUOT_W-1]};
			low_q  <= {low_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

### design/piecewise_linear_table_interp_top.sv
// piecewise linear interpolation table: breakpoint memories, search sequencer, blend
// clear, append, rejected items go to S_DONE and raise out_valid when the output is free
// a query first runs a binary search of at most ceil(log2(points)) steps
// each step reads the single memory read port then compares; segment, divide, blend follow
// one item at a time: the next item can be taken in the cycle in which out_valid rises
// reset clears the point count and sets top_radius to 1.0; memories hold no reset
`timescale 1ns / 1ps
`include "piecewise_linear_table_interp_top_macros.svh"
module piecewise_linear_table_interp_top #(
	parameter int unsigned MAX_POINTS      = pwlti_pkg::MAX_POINTS_DEF,
	parameter int unsigned MATCH_TOLERANCE = pwlti_pkg::MATCH_TOL_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pwlti_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pwlti_pkg::out_item_t out_item
);
	import pwlti_pkg::*;

	localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
	localparam logic [32:0] TOL33 = 33'(MATCH_TOLERANCE);

	logic [31:0] rad_mem [MAX_POINTS];
	logic [31:0] val_mem [MAX_POINTS];

	state_t state_q, state_n;

	logic [CNT_W-1:0] count_q;
	logic [31:0]      last_q;
	logic [31:0]      top_q;
	logic [31:0]      r_q;
	logic [CNT_W-1:0] lo_q, hi_q, mid_q;
	logic [31:0]      rd_rad_q, rd_val_q;
	logic [31:0]      lo_rad_q, v0_q, v1_q, w_q;
	logic signed [32:0] d_q;
	logic signed [LIM_W-1:0] lim_lo_q, lim_hi_q;
	logic [31:0]      diff_mag_q;
	logic             diff_neg_q;
	logic [62:0]      prod_q;
	logic             neg_q;
	logic [31:0]      res_val_q;
	logic [2:0]       res_st_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             accept;
	logic             full, not_inc, wr_en;
	logic [IDX_W-1:0] rd_addr;
	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid;
	logic             srch_lt;
	logic [CNT_W-1:0] lo_n, hi_n;
	logic             seg_ok;
	logic signed [LIM_W-1:0] d_ext, dw_ext, w_ext, neg_w;
	logic             lim_fail;
	logic signed [32:0] diff;
	logic [32:0]      d_mag;
	logic [NUM_W-1:0] div_num;
	logic             div_start, div_done;
	logic [QUOT_W-1:0] quot;
	logic [63:0]      rnd_sum;
	logic [33:0]      pm;
	logic signed [35:0] v0_ext, res_full;
	logic [31:0]      res_sat;
	logic             out_free;

	assign accept   = in_valid & ~in_stall;
	assign full     = (count_q == CNT_W'(MAX_POINTS));
	assign not_inc  = (count_q != '0) && (in_item.radius <= last_q);
	assign wr_en    = accept && (in_item.opcode == OP_APPEND) && !full && !not_inc;
	assign out_free = ~out_valid_q | ~out_stall;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];
	assign srch_lt = {1'b0, r_q} < ({1'b0, rd_rad_q} + TOL33);
	assign lo_n    = srch_lt ? lo_q : mid_q + 1'b1;
	assign hi_n    = srch_lt ? mid_q : hi_q;
	assign seg_ok  = ({1'b0, r_q} + TOL33) > {1'b0, lo_rad_q};

	assign d_ext    = {{(LIM_W-33){d_q[32]}}, d_q};
	assign w_ext    = $signed({{(LIM_W-32){1'b0}}, w_q});
	assign dw_ext   = d_ext - w_ext;
	assign neg_w    = -w_ext;
	assign lim_fail = (lim_lo_q < neg_w) || (lim_hi_q > w_ext);
	assign diff     = $signed({v1_q[31], v1_q}) - $signed({v0_q[31], v0_q});
	assign d_mag    = d_q[32] ? 33'(-d_q) : 33'(d_q);
	assign div_num  = {1'b0, d_mag, 30'd0} + {33'd0, w_q[31:1]};

	assign rnd_sum  = {1'b0, prod_q} + 64'(1 << 29);
	assign pm       = rnd_sum[63:30];
	assign v0_ext   = $signed({{4{v0_q[31]}}, v0_q});
	assign res_full = neg_q ? v0_ext - $signed({2'b00, pm}) : v0_ext + $signed({2'b00, pm});
	always_comb begin
		if (res_full > 36'sd2147483647) begin
			res_sat = 32'h7FFF_FFFF;
		end else if (res_full < -36'sd2147483648) begin
			res_sat = 32'h8000_0000;
		end else begin
			res_sat = res_full[31:0];
		end
	end

	pwlti_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (w_q),
		.done  (div_done),
		.quot  (quot)
	);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_item.opcode == OP_QUERY && count_q >= CNT_W'(2)) begin
						state_n = S_SRCH_RD;
					end else begin
						state_n = S_DONE;
					end
				end
			end
			S_SRCH_RD: state_n = S_SRCH_CMP;
			S_SRCH_CMP: begin
				if (lo_n != hi_n) begin
					state_n = S_SRCH_RD;
				end else if (lo_n == count_q) begin
					state_n = S_DONE;
				end else begin
					state_n = S_SEG_LO;
				end
			end
			S_SEG_LO:  state_n = S_SEG_HI;
			S_SEG_HI:  state_n = S_SEG_CHK;
			S_SEG_CHK: state_n = seg_ok ? S_LIM : S_DONE;
			S_LIM:     state_n = S_LIM_CHK;
			S_LIM_CHK: state_n = lim_fail ? S_DONE : S_DIV;
			S_DIV:     state_n = div_done ? S_MUL : S_DIV;
			S_MUL:     state_n = S_FIN;
			S_FIN:     state_n = S_DONE;
			S_DONE:    state_n = out_free ? S_IDLE : S_DONE;
			default:   state_n = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = 1'b1;
		rd_addr   = '0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE:    in_stall = 1'b0;
			S_SRCH_RD: rd_addr = mid[IDX_W-1:0];
			S_SEG_LO: begin
				rd_addr = IDX_W'(lo_q - 1'b1);
			end
			S_SEG_HI:  rd_addr = lo_q[IDX_W-1:0];
			S_LIM_CHK: div_start = ~lim_fail;
			default:   in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			top_q       <= TOP_RADIUS_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid) begin
				top_q <= cfg_data;
			end
			if (accept && in_item.opcode == OP_CLEAR) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rad_mem[count_q[IDX_W-1:0]] <= in_item.radius;
			val_mem[count_q[IDX_W-1:0]] <= in_item.point_value;
		end
		rd_rad_q <= rad_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_val_q <= '0;
					r_q       <= (in_item.radius > top_q) ? top_q : in_item.radius;
					lo_q      <= CNT_W'(1);
					hi_q      <= count_q;
					case (in_item.opcode)
						OP_CLEAR:  res_st_q <= STS_CLEARED;
						OP_APPEND: begin
							if (full) begin
								res_st_q <= STS_FULL;
							end else if (not_inc) begin
								res_st_q <= STS_NOT_INC;
							end else begin
								res_st_q <= STS_STORED;
								last_q   <= in_item.radius;
							end
						end
						OP_QUERY:  res_st_q <= STS_TOO_FEW;
						default:   res_st_q <= STS_RANGE;
					endcase
				end
			end
			S_SRCH_RD: mid_q <= mid;
			S_SRCH_CMP: begin
				lo_q     <= lo_n;
				hi_q     <= hi_n;
				res_st_q <= STS_RANGE;
			end
			S_SEG_HI: begin
				lo_rad_q <= rd_rad_q;
				v0_q     <= rd_val_q;
			end
			S_SEG_CHK: begin
				w_q  <= rd_rad_q - lo_rad_q;
				d_q  <= $signed({1'b0, r_q}) - $signed({1'b0, lo_rad_q});
				v1_q <= rd_val_q;
			end
			S_LIM: begin
				lim_lo_q   <= LIM_W'(d_ext * ETA_LO_MUL);
				lim_hi_q   <= LIM_W'(dw_ext * ETA_HI_MUL);
				diff_neg_q <= diff[32];
				diff_mag_q <= diff[32] ? 32'(-diff) : diff[31:0];
			end
			S_MUL: begin
				prod_q <= diff_mag_q * quot;
				neg_q  <= diff_neg_q ^ d_q[32];
			end
			S_FIN: begin
				res_val_q <= res_sat;
				res_st_q  <= STS_OK;
			end
			S_DONE: begin
				if (out_free) begin
					out_q.interp_value <= res_val_q;
					out_q.status       <= res_st_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`PWLTI_AST_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_POINTS))
	`PWLTI_AST_NEXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE)
	`PWLTI_AST_SAME(a_div_done_state, clk, arst_n, div_done, state_q == S_DIV)
	`PWLTI_AST_SAME(a_search_open, clk, arst_n, state_q == S_SRCH_CMP, lo_q < hi_q)
endmodule
